/* rtl/core/ial_pkg.sv */
// Shared types and constants for the indexed array list.
package ial_pkg;

   localparam int DEPTH   = 16;
   localparam int DATA_W  = 32;
   localparam int CNT_W   = 5;
   localparam int POS_W   = $clog2(DEPTH);

   typedef enum logic [1:0] {
      KIND_APPEND = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_DELETE = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_FULL   = 2'd1,
      ST_BADIDX = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_SHIFT_UP,
      CELL_SHIFT_DOWN
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic signed [DATA_W-1:0] value;
   } cell_ctl_type;

endpackage

/* rtl/core/ial_cell.sv */
// One list position: holds a word and takes a new one, or a neighbor's, when told.
module ial_cell
   import ial_pkg::*;
(
   input  logic                     clock,
   input  cell_ctl_type             ctl,
   input  logic signed [DATA_W-1:0] lower_data,
   input  logic signed [DATA_W-1:0] upper_data,
   output logic signed [DATA_W-1:0] data
);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   always_comb begin
      unique case (ctl.op)
         CELL_LOAD:       data_in = ctl.value;
         CELL_SHIFT_UP:   data_in = lower_data;
         CELL_SHIFT_DOWN: data_in = upper_data;
         default:         data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

/* rtl/core/indexed_array_list.sv */
// Top level of the indexed array list: request decode, row of cells, result register.
//
// An ordered list of signed 32-bit words held in a row of DEPTH cells.
// Request channel (req_): kind, index and value; one item per request.
// Kinds are append, insert at index, delete at index and read at index.
// Result channel (rsp_): the deleted or read word, a status (ok, full,
// bad index) and the list length after the request.
// Every request gives one result, registered and shown in the cycle after it is accepted.
// Throughput is one item per cycle while rsp_ready is high: all cells shift
// in parallel in the cycle the item is accepted; the result lands in an output register.
// A request is taken while the output register is empty or being drained,
// so a stalled receiver holds req_ready low once a result is waiting.
// csr_wr_en writes the capacity register; write it only while idle.
// Reset empties the list, sets capacity to 16 and clears rsp_valid.
// Cell contents are not cleared; positions at or above the length are
// never returned.
module indexed_array_list_core
   import ial_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_kind,
   input  logic [4:0]               req_index,
   input  logic signed [31:0]       req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [31:0]       rsp_result_value,
   output logic [1:0]               rsp_status,
   output logic [4:0]               rsp_count,
   input  logic                     csr_wr_en,
   input  logic [4:0]               csr_wr_data
);

   logic [CNT_W-1:0]         capacity_ff;
   logic [CNT_W-1:0]         fill_ff;
   logic [CNT_W-1:0]         fill_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic signed [DATA_W-1:0] rsp_value_in;
   status_type               rsp_status_ff;
   status_type               rsp_status_in;

   logic                     req_fire;
   kind_type                 kind;
   logic [CNT_W-1:0]         limit;
   logic                     full;
   logic                     idx_in_list;
   logic                     idx_ins_ok;
   logic signed [DATA_W-1:0] picked;

   cell_ctl_type             cell_ctl [DEPTH];
   logic signed [DATA_W-1:0] cell_data [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign kind      = kind_type'(req_kind);

   // Capacity above the row length saturates to the row length.
   assign limit       = (capacity_ff > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity_ff;
   assign full        = fill_ff >= limit;
   assign idx_in_list = req_index < fill_ff;
   assign idx_ins_ok  = req_index <= fill_ff;
   assign picked      = cell_data[req_index[POS_W-1:0]];

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         localparam logic [CNT_W-1:0] POS = CNT_W'(gi);

         always_comb begin
            cell_ctl[gi].value = req_value;
            cell_ctl[gi].op    = CELL_HOLD;
            if (req_fire) begin
               unique case (kind)
                  KIND_APPEND: begin
                     if (!full && POS == fill_ff) cell_ctl[gi].op = CELL_LOAD;
                  end
                  KIND_INSERT: begin
                     if (idx_ins_ok && !full) begin
                        if (POS == req_index)     cell_ctl[gi].op = CELL_LOAD;
                        else if (POS > req_index) cell_ctl[gi].op = CELL_SHIFT_UP;
                     end
                  end
                  KIND_DELETE: begin
                     if (idx_in_list && POS >= req_index) cell_ctl[gi].op = CELL_SHIFT_DOWN;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ial_cell u_cell (
            .clock      (clock),
            .ctl        (cell_ctl[gi]),
            .lower_data ((gi == 0) ? '0 : cell_data[(gi == 0) ? 0 : gi - 1]),
            .upper_data ((gi == DEPTH - 1) ? '0 : cell_data[(gi == DEPTH - 1) ? gi : gi + 1]),
            .data       (cell_data[gi])
         );
      end
   endgenerate

   always_comb begin
      fill_in       = fill_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      if (req_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_status_in = ST_OK;
         unique case (kind)
            KIND_APPEND: begin
               if (full) rsp_status_in = ST_FULL;
               else      fill_in = fill_ff + CNT_W'(1);
            end
            KIND_INSERT: begin
               if (!idx_ins_ok)  rsp_status_in = ST_BADIDX;
               else if (full)    rsp_status_in = ST_FULL;
               else              fill_in = fill_ff + CNT_W'(1);
            end
            KIND_DELETE: begin
               if (!idx_in_list) begin
                  rsp_status_in = ST_BADIDX;
               end else begin
                  rsp_value_in = picked;
                  fill_in      = fill_ff - CNT_W'(1);
               end
            end
            default: begin
               if (!idx_in_list) rsp_status_in = ST_BADIDX;
               else              rsp_value_in = picked;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CNT_W'(16);
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) capacity_ff <= csr_wr_data;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_count        = fill_ff;

endmodule

/* rtl/core/ial_checker.sv */
// Port-level checks for the indexed array list, bound to the top level.
module ial_checker
   import ial_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_result_value,
   input logic [1:0]         rsp_status,
   input logic [4:0]         rsp_count
);

   // A waiting result holds until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
         && $stable(rsp_status) && $stable(rsp_count))
      else $error("result changed while stalled");

   // Every accepted item shows a result in the next cycle.
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item gave no result");

   // A rejected request returns a zero word.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_result_value == 0)
      else $error("error result carries a word");

   // The list never grows past the row.
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_count <= 5'(DEPTH))
      else $error("list length above depth");

endmodule

bind indexed_array_list_core ial_checker u_ial_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_result_value (rsp_result_value),
   .rsp_status       (rsp_status),
   .rsp_count        (rsp_count)
);

/* tb/sv/indexed_array_list_core_tb.sv */
// Self-checking testbench for the indexed array list core, with a shadow list and a scoreboard.
`timescale 1ns / 100ps

module indexed_array_list_core_tb;
   import ial_pkg::*;

   typedef struct {
      logic signed [DATA_W-1:0] word;
      status_type               st;
      logic [CNT_W-1:0]         len;
   } list_reply_type;

   // Shadow copy of the list plus the queue of replies it still owes.
   class list_shadow_type;
      logic signed [DATA_W-1:0] slots [DEPTH];
      int unsigned              fill;
      logic [CNT_W-1:0]         capacity;
      list_reply_type           awaited [$];
      int                       errors;

      function new();
         foreach (slots[i]) slots[i] = '0;
         fill = 0;
         capacity = 5'd16;
         errors = 0;
      endfunction

      task report(input string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         errors++;
      endtask

      function list_reply_type apply_request(input kind_type kind, input logic [4:0] idx,
                                             input logic signed [DATA_W-1:0] word);
         list_reply_type r;
         int unsigned lim;
         r.word = '0;
         r.st = ST_OK;
         lim = (capacity > DEPTH) ? DEPTH : capacity;
         case (kind)
            KIND_APPEND: begin
               if (fill >= lim) begin
                  r.st = ST_FULL;
               end else begin
                  slots[fill] = word;
                  fill++;
               end
            end
            KIND_INSERT: begin
               // A bad index wins over a full list.
               if (idx > fill) begin
                  r.st = ST_BADIDX;
               end else if (fill >= lim) begin
                  r.st = ST_FULL;
               end else begin
                  for (int i = fill; i > idx; i--) slots[i] = slots[i-1];
                  slots[idx] = word;
                  fill++;
               end
            end
            KIND_DELETE: begin
               if (idx >= fill) begin
                  r.st = ST_BADIDX;
               end else begin
                  r.word = slots[idx];
                  for (int i = idx; i + 1 < fill; i++) slots[i] = slots[i+1];
                  fill--;
               end
            end
            default: begin
               if (idx >= fill) r.st = ST_BADIDX;
               else r.word = slots[idx];
            end
         endcase
         r.len = CNT_W'(fill);
         return r;
      endfunction

      function void note_request(input kind_type kind, input logic [4:0] idx,
                                 input logic signed [DATA_W-1:0] word);
         awaited.push_back(apply_request(kind, idx, word));
      endfunction

      task check_result(input logic signed [DATA_W-1:0] word, input logic [1:0] st,
                        input logic [CNT_W-1:0] len);
         list_reply_type exp;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected result: value %0d status %0d count %0d",
                             word, st, len));
            return;
         end
         exp = awaited.pop_front();
         if (word !== exp.word)
            report($sformatf("result value got %0d, wanted %0d", word, exp.word));
         if (st !== exp.st)
            report($sformatf("status code got %0d, wanted %0d", st, exp.st));
         if (len !== exp.len)
            report($sformatf("count got %0d, wanted %0d", len, exp.len));
      endtask
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_kind = KIND_APPEND;
   logic [4:0]         req_index = '0;
   logic signed [31:0] req_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_result_value;
   logic [1:0]         rsp_status;
   logic [4:0]         rsp_count;
   logic               csr_wr_en = 1'b0;
   logic [4:0]         csr_wr_data = '0;
   bit                 steady = 1'b0;

   list_shadow_type shadow = new();

   indexed_array_list_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_index        (req_index),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_count        (rsp_count),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #6 clock = ~clock;

   // The receiver stalls now and then, except during the steady stretch.
   always @(negedge clock) begin
      rsp_ready = steady ? 1'b1 : ($urandom_range(99) >= 18);
   end

   // Results are checked before the new item is noted, so an item and its
   // reply never race inside the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            shadow.check_result(rsp_result_value, rsp_status, rsp_count);
         if (req_valid && req_ready)
            shadow.note_request(kind_type'(req_kind), req_index, req_value);
      end
   end

   task automatic send_request(input kind_type kind, input logic [4:0] idx,
                               input logic signed [31:0] word);
      req_valid = 1'b1;
      req_kind  = kind;
      req_index = idx;
      req_value = word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (!steady) begin
         while ($urandom_range(99) < 18) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
      end
   endtask

   // The capacity is only changed once every reply has come back.
   task automatic set_capacity(input logic [4:0] cap);
      req_valid = 1'b0;
      while (shadow.awaited.size() != 0) @(negedge clock);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = cap;
      @(negedge clock);
      csr_wr_en = 1'b0;
      shadow.capacity = cap;
   endtask

   function automatic logic signed [31:0] pick_word();
      case ($urandom_range(9))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 32'sd0;
         3: return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // Mostly positions near the current length, sometimes anywhere in range.
   function automatic logic [4:0] pick_index();
      int unsigned top;
      top = (shadow.fill + 1 > 31) ? 31 : shadow.fill + 1;
      if ($urandom_range(99) < 80) return 5'($urandom_range(top));
      return 5'($urandom_range(31));
   endfunction

   initial begin
      int           grow [9] = '{70, 60, 50, 70, 40, 75, 50, 65, 30};
      logic [4:0]   caps [9] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd7, 5'd16, 5'd2, 5'd17, 5'd16};
      int unsigned  r;
      int           wait_cycles;
      kind_type     kind;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at the reset capacity.
      send_request(KIND_READ,   5'd0,  32'sd5);
      send_request(KIND_DELETE, 5'd0,  32'sd5);
      send_request(KIND_INSERT, 5'd1,  32'sd9);
      send_request(KIND_INSERT, 5'd0,  32'sh7fffffff);
      send_request(KIND_APPEND, 5'd31, 32'sh80000000);
      send_request(KIND_APPEND, 5'd0,  32'sd0);
      send_request(KIND_APPEND, 5'd0,  -32'sd1);
      send_request(KIND_INSERT, 5'd4,  32'sh12345678);
      send_request(KIND_INSERT, 5'd1,  32'sh5a5a5a5a);
      send_request(KIND_READ,   5'd5,  32'sd0);
      send_request(KIND_READ,   5'd31, 32'sd0);
      send_request(KIND_DELETE, 5'd0,  32'sd0);
      send_request(KIND_DELETE, 5'd5,  32'sd0);
      send_request(KIND_DELETE, 5'd4,  32'sd0);
      send_request(KIND_INSERT, 5'd31, 32'sd1);
      send_request(KIND_DELETE, 5'd31, 32'sd0);
      send_request(KIND_READ,   5'd16, 32'sd0);

      // Capacity below the current length: growth is refused, the rest works.
      set_capacity(5'd2);
      send_request(KIND_APPEND, 5'd0, 32'sd11);
      send_request(KIND_INSERT, 5'd0, 32'sd12);
      send_request(KIND_INSERT, 5'd9, 32'sd13);
      send_request(KIND_READ,   5'd0, 32'sd0);
      send_request(KIND_DELETE, 5'd0, 32'sd0);

      // With a capacity of zero, every append and insert is refused.
      set_capacity(5'd0);
      send_request(KIND_APPEND, 5'd0, 32'sd21);
      send_request(KIND_INSERT, 5'd0, 32'sd22);

      // Random phases, each at its own capacity and with its own bias toward
      // growing or shrinking the list.
      for (int ph = 0; ph < 9; ph++) begin
         set_capacity((ph == 4) ? 5'($urandom_range(31)) : caps[ph]);
         steady = (ph == 5);
         for (int n = 0; n < 150; n++) begin
            r = $urandom_range(99);
            if (r < grow[ph])
               kind = (r % 2 == 0) ? KIND_APPEND : KIND_INSERT;
            else
               kind = (r % 2 == 0) ? KIND_DELETE : KIND_READ;
            send_request(kind, pick_index(), pick_word());
         end
         steady = 1'b0;
      end

      req_valid = 1'b0;
      wait_cycles = 0;
      while (shadow.awaited.size() != 0 && wait_cycles < 2000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (4) @(negedge clock);
      if (shadow.awaited.size() != 0)
         shadow.report($sformatf("%0d expected results never arrived",
                                 shadow.awaited.size()));
      if (shadow.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
